// ===== sv/ook_pkg.sv =====
// shared types, constants and the segment length table of the ook pulse encoder
package ook_pkg;

  localparam int CODE_BITS_DEF = 26;

  localparam int TX_CODE_W    = 26;
  localparam int CHAN_W       = 3;
  localparam int UNIT_NUM_W   = 3;
  localparam int UNIT_TICKS_W = 16;
  localparam int REPEATS_W    = 4;
  localparam int UNITS_W      = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 26;

  localparam logic [CFG_IDX_W-1:0] CFG_TX_CODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SELECT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_NUMBER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TICKS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEATS      = 3'd5;

  localparam logic [CHAN_W-1:0]       CHANNEL_RST     = 3'd1;
  localparam logic [UNIT_NUM_W-1:0]   UNIT_NUMBER_RST = 3'd1;
  localparam logic [UNIT_TICKS_W-1:0] UNIT_TICKS_RST  = 16'd250;
  localparam logic [REPEATS_W-1:0]    REPEATS_RST     = 4'd5;

  localparam logic [UNITS_W-1:0] SHORT_UNITS     = 6'd1;
  localparam logic [UNITS_W-1:0] LONG_UNITS      = 6'd5;
  localparam logic [UNITS_W-1:0] SYNC_LOW_UNITS  = 6'd10;
  localparam logic [UNITS_W-1:0] PAUSE_LOW_UNITS = 6'd40;

  typedef enum logic [1:0] {
    SYM_SYNC  = 2'd0,
    SYM_ZERO  = 2'd1,
    SYM_ONE   = 2'd2,
    SYM_PAUSE = 2'd3
  } sym_kind_t;

  // settings that pick the data symbols of a packet
  typedef struct packed {
    logic [TX_CODE_W-1:0]  tx_code;
    logic                  group_select;
    logic [CHAN_W-1:0]     channel;
    logic [UNIT_NUM_W-1:0] unit_number;
  } sym_cfg_t;

  // units in one segment; even phases are high, odd phases low
  function automatic logic [UNITS_W-1:0] seg_units(sym_kind_t kind, logic [1:0] phase);
    logic [UNITS_W-1:0] u;
    u = SHORT_UNITS;
    unique case (kind)
      SYM_SYNC:  u = (phase == 2'd1) ? SYNC_LOW_UNITS : SHORT_UNITS;
      SYM_PAUSE: u = (phase == 2'd1) ? PAUSE_LOW_UNITS : SHORT_UNITS;
      SYM_ZERO:  u = (phase == 2'd1) ? LONG_UNITS : SHORT_UNITS;
      SYM_ONE:   u = (phase == 2'd3) ? LONG_UNITS : SHORT_UNITS;
    endcase
    return u;
  endfunction

endpackage

// ===== sv/ook_symbol_sel.sv =====
// picks the symbol kind for one position of the packet
module ook_symbol_sel #(
  parameter int CODE_BITS = ook_pkg::CODE_BITS_DEF
) (
  input  logic [$clog2(CODE_BITS+8)-1:0] symbol_index,
  input  ook_pkg::sym_cfg_t              cfg,
  input  logic                           on_latched,
  output ook_pkg::sym_kind_t             kind
);
  import ook_pkg::*;

  localparam int SYM_W = $clog2(CODE_BITS + 8);
  localparam int IDX_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;

  localparam logic [SYM_W-1:0] CODE_LAST  = SYM_W'(CODE_BITS);
  localparam logic [SYM_W-1:0] OFS_GROUP  = SYM_W'(1);
  localparam logic [SYM_W-1:0] OFS_ONOFF  = SYM_W'(2);
  localparam logic [SYM_W-1:0] OFS_CHAN_H = SYM_W'(3);
  localparam logic [SYM_W-1:0] OFS_CHAN_L = SYM_W'(4);
  localparam logic [SYM_W-1:0] OFS_UNIT_H = SYM_W'(5);
  localparam logic [SYM_W-1:0] OFS_UNIT_L = SYM_W'(6);

  // 1..4 sent as 4 minus value, out of range clamped
  function automatic logic [1:0] inv_code(logic [2:0] v);
    logic [2:0] c;
    c = v;
    if (v == 3'd0) c = 3'd1;
    else if (v > 3'd4) c = 3'd4;
    return 2'(3'd4 - c);
  endfunction

  logic [CODE_BITS-1:0] code_msb;
  logic [SYM_W-1:0]     code_pos;
  logic [SYM_W-1:0]     tail_ofs;
  logic [1:0]           chan_bits;
  logic [1:0]           unit_bits;

  // code bits in send order, zero above the register width
  for (genvar j = 0; j < CODE_BITS; j++) begin : g_code
    if (CODE_BITS - 1 - j < TX_CODE_W) begin : g_in
      assign code_msb[j] = cfg.tx_code[CODE_BITS-1-j];
    end else begin : g_pad
      assign code_msb[j] = 1'b0;
    end
  end

  assign code_pos  = symbol_index - SYM_W'(1);
  assign tail_ofs  = symbol_index - CODE_LAST;
  assign chan_bits = inv_code(cfg.channel);
  assign unit_bits = inv_code(cfg.unit_number);

  always_comb begin
    priority if (symbol_index == '0) begin
      kind = SYM_SYNC;
    end else if (symbol_index <= CODE_LAST) begin
      kind = code_msb[code_pos[IDX_W-1:0]] ? SYM_ONE : SYM_ZERO;
    end else if (tail_ofs == OFS_GROUP) begin
      kind = cfg.group_select ? SYM_ZERO : SYM_ONE;
    end else if (tail_ofs == OFS_ONOFF) begin
      kind = on_latched ? SYM_ZERO : SYM_ONE;
    end else if (tail_ofs == OFS_CHAN_H) begin
      kind = chan_bits[1] ? SYM_ONE : SYM_ZERO;
    end else if (tail_ofs == OFS_CHAN_L) begin
      kind = chan_bits[0] ? SYM_ONE : SYM_ZERO;
    end else if (tail_ofs == OFS_UNIT_H) begin
      kind = unit_bits[1] ? SYM_ONE : SYM_ZERO;
    end else if (tail_ofs == OFS_UNIT_L) begin
      kind = unit_bits[0] ? SYM_ONE : SYM_ZERO;
    end else begin
      kind = SYM_PAUSE;
    end
  end

endmodule

// ===== sv/ook_remote_pulse_encoder.sv =====
// top level of the ook remote pulse encoder
// Each request is either one base tick (action 0) or a start of a packet train (action 1),
// and yields exactly one result: the pin level after it, the busy flag and a flag that a
// start came while busy and was dropped. One request is taken per clock while in_stall is low;
// a request goes through an input register and then the output register, where it is
// held while out_stall is high. A packet is a sync symbol, CODE_BITS code bits sent msb
// first, the group and on/off bits (sent inverted), two channel and two unit bits coded as
// 4 minus the value, and a pause symbol; it is repeated the configured number of times.
// Each time unit T lasts unit_ticks tick requests. The user must write registers through the
// cfg port only while no request is in flight; the block does not enforce this. A write
// during a packet train is used from the next unit reload or symbol choice on.
module ook_remote_pulse_encoder #(
  parameter int CODE_BITS = ook_pkg::CODE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           action,
  input  logic                           turn_on,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           pin_level,
  output logic                           busy_res,
  output logic                           start_ignored,
  input  logic                           cfg_we,
  input  logic [ook_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ook_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ook_pkg::*;

  localparam int SYM_W = $clog2(CODE_BITS + 8);
  localparam logic [SYM_W-1:0] SYM_LAST = SYM_W'(CODE_BITS + 7);

  // configuration registers
  sym_cfg_t                scfg;
  logic [UNIT_TICKS_W-1:0] unit_ticks;
  logic [REPEATS_W-1:0]    repeats;

  // input register
  logic s1_valid;
  logic s1_action;
  logic s1_turn_on;
  logic s1_move;
  logic advance;

  // encoder state
  logic                    active,        active_next;
  logic                    line_level,    line_level_next;
  logic                    on_latched,    on_latched_next;
  logic [REPEATS_W-1:0]    packet_count,  packet_count_next;
  logic [SYM_W-1:0]        symbol_index,  symbol_index_next;
  logic [1:0]              segment_phase, segment_phase_next;
  logic [UNITS_W-1:0]      units_left,    units_left_next;
  logic [UNIT_TICKS_W-1:0] ticks_left,    ticks_left_next;
  logic                    ignored_next;

  sym_kind_t               kind_cur;
  sym_kind_t               kind_inc;
  logic [SYM_W-1:0]        symbol_inc;
  logic [UNIT_TICKS_W-1:0] eff_ticks;
  logic [REPEATS_W-1:0]    eff_repeats;
  logic [REPEATS_W-1:0]    packet_inc;
  logic [1:0]              last_phase;
  logic [1:0]              phase_inc;

  assign s1_move  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_move;
  assign advance  = s1_valid && s1_move;

  assign symbol_inc  = symbol_index + SYM_W'(1);
  assign phase_inc   = segment_phase + 2'd1;
  assign packet_inc  = packet_count + REPEATS_W'(1);
  assign eff_ticks   = (unit_ticks == '0) ? UNIT_TICKS_W'(1) : unit_ticks;
  assign eff_repeats = (repeats == '0) ? REPEATS_W'(1) : repeats;
  assign last_phase  = (kind_cur == SYM_SYNC || kind_cur == SYM_PAUSE) ? 2'd1 : 2'd3;

  ook_symbol_sel #(.CODE_BITS(CODE_BITS)) u_sel_cur (
    .symbol_index (symbol_index),
    .cfg          (scfg),
    .on_latched   (on_latched),
    .kind         (kind_cur)
  );

  ook_symbol_sel #(.CODE_BITS(CODE_BITS)) u_sel_inc (
    .symbol_index (symbol_inc),
    .cfg          (scfg),
    .on_latched   (on_latched),
    .kind         (kind_inc)
  );

  always_comb begin
    active_next        = active;
    line_level_next    = line_level;
    on_latched_next    = on_latched;
    packet_count_next  = packet_count;
    symbol_index_next  = symbol_index;
    segment_phase_next = segment_phase;
    units_left_next    = units_left;
    ticks_left_next    = ticks_left;
    ignored_next       = 1'b0;
    if (s1_action) begin
      if (active) begin
        ignored_next = 1'b1;
      end else begin
        // start: pin goes high at once, first unit of the sync symbol
        on_latched_next    = s1_turn_on;
        active_next        = 1'b1;
        packet_count_next  = '0;
        symbol_index_next  = '0;
        segment_phase_next = '0;
        units_left_next    = seg_units(SYM_SYNC, 2'd0);
        ticks_left_next    = eff_ticks;
        line_level_next    = 1'b1;
      end
    end else if (active) begin
      priority if (ticks_left > UNIT_TICKS_W'(1)) begin
        ticks_left_next = ticks_left - UNIT_TICKS_W'(1);
      end else if (units_left > UNITS_W'(1)) begin
        units_left_next = units_left - UNITS_W'(1);
        ticks_left_next = eff_ticks;
      end else if (segment_phase < last_phase) begin
        segment_phase_next = phase_inc;
        units_left_next    = seg_units(kind_cur, phase_inc);
        ticks_left_next    = eff_ticks;
        line_level_next    = !phase_inc[0];
      end else if (symbol_index < SYM_LAST) begin
        segment_phase_next = '0;
        symbol_index_next  = symbol_inc;
        units_left_next    = seg_units(kind_inc, 2'd0);
        ticks_left_next    = eff_ticks;
        line_level_next    = 1'b1;
      end else if (packet_inc >= eff_repeats) begin
        // train done
        segment_phase_next = '0;
        symbol_index_next  = '0;
        active_next        = 1'b0;
        line_level_next    = 1'b0;
        packet_count_next  = '0;
        units_left_next    = '0;
        ticks_left_next    = '0;
      end else begin
        segment_phase_next = '0;
        symbol_index_next  = '0;
        packet_count_next  = packet_inc;
        units_left_next    = seg_units(SYM_SYNC, 2'd0);
        ticks_left_next    = eff_ticks;
        line_level_next    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scfg.tx_code      <= '0;
      scfg.group_select <= 1'b0;
      scfg.channel      <= CHANNEL_RST;
      scfg.unit_number  <= UNIT_NUMBER_RST;
      unit_ticks        <= UNIT_TICKS_RST;
      repeats           <= REPEATS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TX_CODE:      scfg.tx_code      <= cfg_data[TX_CODE_W-1:0];
        CFG_GROUP_SELECT: scfg.group_select <= cfg_data[0];
        CFG_CHANNEL:      scfg.channel      <= cfg_data[CHAN_W-1:0];
        CFG_UNIT_NUMBER:  scfg.unit_number  <= cfg_data[UNIT_NUM_W-1:0];
        CFG_UNIT_TICKS:   unit_ticks        <= cfg_data[UNIT_TICKS_W-1:0];
        CFG_REPEATS:      repeats           <= cfg_data[REPEATS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      active        <= 1'b0;
      line_level    <= 1'b0;
      on_latched    <= 1'b0;
      packet_count  <= '0;
      symbol_index  <= '0;
      segment_phase <= '0;
      units_left    <= '0;
      ticks_left    <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= s1_valid;
      end
      if (advance) begin
        active        <= active_next;
        line_level    <= line_level_next;
        on_latched    <= on_latched_next;
        packet_count  <= packet_count_next;
        symbol_index  <= symbol_index_next;
        segment_phase <= segment_phase_next;
        units_left    <= units_left_next;
        ticks_left    <= ticks_left_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action  <= action;
      s1_turn_on <= turn_on;
    end
    if (advance) begin
      pin_level     <= line_level_next;
      busy_res      <= active_next;
      start_ignored <= ignored_next;
    end
  end

  a_idle_pin_low : assert property (@(posedge clk) disable iff (rst)
    !active |-> !line_level)
    else $error("pin high while idle");

  a_counts_loaded : assert property (@(posedge clk) disable iff (rst)
    active |-> (units_left != '0 && ticks_left != '0))
    else $error("empty unit or tick count while active");

  a_symbol_range : assert property (@(posedge clk) disable iff (rst)
    active |-> symbol_index <= SYM_LAST)
    else $error("symbol position past pause");

  a_ignored_busy : assert property (@(posedge clk) disable iff (rst)
    (out_valid && start_ignored) |-> busy_res)
    else $error("dropped start reported while idle");

endmodule
